### rtl/wth_pkg.sv
// ----------------------------------------------------------------------------
// wth_pkg
// Shared types, constants and character classes for the whitespace tokenizer.
// ----------------------------------------------------------------------------
package wth_pkg;

	localparam int unsigned CP_WIDTH  = 21;
	localparam int unsigned HASH_W    = 32;
	localparam int unsigned LIMIT_W   = 16;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [HASH_W-1:0]  HASH_INIT = 32'd5381;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'hFFFF;

	// utf-8 lead byte masks and patterns
	localparam logic [7:0] ASCII_TOP  = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_PAT  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_PAT  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_PAT  = 8'hF0;
	localparam logic [7:0] LEAD2_BITS = 8'h1F;
	localparam logic [7:0] LEAD3_BITS = 8'h0F;
	localparam logic [7:0] LEAD4_BITS = 8'h07;
	localparam logic [7:0] CONT_BITS  = 8'h3F;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOWERCASE   = 8'd0,
		REG_DROP_PUNCT  = 8'd1,
		REG_UTF8        = 8'd2,
		REG_TOKEN_LIMIT = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic               lowercase_mode;
		logic               drop_punctuation;
		logic               utf8_mode;
		logic [LIMIT_W-1:0] token_limit;
	} cfg_t;

	function automatic logic is_space(input logic [CP_WIDTH-1:0] c);
		return (c == 21'h20) || (c == 21'h09) || (c == 21'h0A) || (c == 21'h0D);
	endfunction

	function automatic logic punct_char(input logic [CP_WIDTH-1:0] c);
		return (c >= 21'h21 && c <= 21'h2F) || (c >= 21'h3A && c <= 21'h40) ||
		       (c >= 21'h5B && c <= 21'h60) || (c >= 21'h7B && c <= 21'h7E);
	endfunction

endpackage

### rtl/wth_engine.sv
// ----------------------------------------------------------------------------
// wth_engine
// Per-text tokenizer state and the combinational update for one text byte.
// ----------------------------------------------------------------------------
module wth_engine import wth_pkg::*; #(
	parameter int unsigned OFFSET_WIDTH = 24,
	parameter int unsigned COUNT_WIDTH  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic [7:0]              text_byte,
	input  logic                    final_byte,
	input  logic                    fire,
	output logic                    has_result,
	output logic                    token_valid,
	output logic [HASH_W-1:0]       res_hash,
	output logic [OFFSET_WIDTH-1:0] start_offset,
	output logic [OFFSET_WIDTH-1:0] end_offset,
	output logic [COUNT_WIDTH-1:0]  tokens_so_far
);

	logic                    inside_q, inside_n;
	logic [HASH_W-1:0]       hash_q, hash_n;
	logic [OFFSET_WIDTH-1:0] tbegin_q, tbegin_n;
	logic [OFFSET_WIDTH-1:0] boff_q, boff_n;
	logic [OFFSET_WIDTH-1:0] cbegin_q, cbegin_n;
	logic [CP_WIDTH-1:0]     partial_q, partial_n;
	logic [1:0]              pend_q, pend_n;
	logic [COUNT_WIDTH-1:0]  count_q, count_n;
	logic                    halted_q, halted_n;

	logic                    have;
	logic [CP_WIDTH-1:0]     cp;

	function automatic logic limit_hit(input logic [COUNT_WIDTH-1:0] cnt,
	                                   input logic [LIMIT_W-1:0] lim);
		return (33'(cnt) >= 33'(lim)) || (&cnt);
	endfunction

	always_comb begin
		inside_n  = inside_q;
		hash_n    = hash_q;
		tbegin_n  = tbegin_q;
		boff_n    = boff_q;
		cbegin_n  = cbegin_q;
		partial_n = partial_q;
		pend_n    = pend_q;
		count_n   = count_q;
		halted_n  = halted_q;
		have         = 1'b0;
		cp           = '0;
		token_valid  = 1'b0;
		res_hash     = '0;
		start_offset = '0;
		end_offset   = '0;

		if (!halted_n && limit_hit(count_q, cfg.token_limit)) begin
			halted_n = 1'b1;
		end

		if (!halted_n) begin
			if (cfg.utf8_mode) begin
				if (pend_q == 2'd0) begin
					cbegin_n = boff_q;
					if (text_byte < ASCII_TOP) begin
						cp   = CP_WIDTH'(text_byte);
						have = 1'b1;
					end else if ((text_byte & LEAD2_MASK) == LEAD2_PAT) begin
						partial_n = CP_WIDTH'(text_byte & LEAD2_BITS);
						pend_n    = 2'd1;
					end else if ((text_byte & LEAD3_MASK) == LEAD3_PAT) begin
						partial_n = CP_WIDTH'(text_byte & LEAD3_BITS);
						pend_n    = 2'd2;
					end else if ((text_byte & LEAD4_MASK) == LEAD4_PAT) begin
						partial_n = CP_WIDTH'(text_byte & LEAD4_BITS);
						pend_n    = 2'd3;
					end else begin
						halted_n = 1'b1;
					end
				end else begin
					// continuation bytes are taken as they come, low six bits only
					partial_n = {partial_q[CP_WIDTH-7:0], text_byte[5:0]};
					pend_n    = pend_q - 2'd1;
					if (pend_n == 2'd0) begin
						cp   = partial_n;
						have = 1'b1;
					end
				end
				if (!halted_n) begin
					boff_n = boff_q + OFFSET_WIDTH'(1);
				end
				// text ends inside a multi-byte sequence
				if (final_byte && !halted_n && pend_n != 2'd0) begin
					halted_n = 1'b1;
				end
			end else begin
				pend_n   = 2'd0;
				cbegin_n = boff_q;
				boff_n   = boff_q + OFFSET_WIDTH'(1);
				cp       = CP_WIDTH'(text_byte);
				have     = 1'b1;
			end

			if (have) begin
				if (is_space(cp) || (cfg.drop_punctuation && punct_char(cp))) begin
					if (inside_q) begin
						token_valid  = 1'b1;
						res_hash     = hash_q;
						start_offset = tbegin_q;
						end_offset   = cbegin_n;
						count_n      = count_q + COUNT_WIDTH'(1);
						inside_n     = 1'b0;
						hash_n       = HASH_INIT;
						if (limit_hit(count_n, cfg.token_limit)) begin
							halted_n = 1'b1;
						end
					end
				end else begin
					if (!inside_q) begin
						tbegin_n = cbegin_n;
						inside_n = 1'b1;
					end
					if (cfg.lowercase_mode && cp >= 21'h41 && cp <= 21'h5A) begin
						cp = cp + 21'h20;
					end
					// hash * 33 + cp as a shift and two adds
					hash_n = {hash_q[HASH_W-6:0], 5'd0} + hash_q + HASH_W'(cp);
				end
			end
		end

		// close an open token at the end of the text
		if (final_byte && !token_valid && inside_n && !limit_hit(count_n, cfg.token_limit)) begin
			token_valid  = 1'b1;
			res_hash     = hash_n;
			start_offset = tbegin_n;
			end_offset   = halted_n ? cbegin_n : boff_n;
			count_n      = count_n + COUNT_WIDTH'(1);
		end

		has_result    = token_valid || final_byte;
		tokens_so_far = count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q  <= 1'b0;
			hash_q    <= HASH_INIT;
			tbegin_q  <= '0;
			boff_q    <= '0;
			cbegin_q  <= '0;
			partial_q <= '0;
			pend_q    <= 2'd0;
			count_q   <= '0;
			halted_q  <= 1'b0;
		end else if (fire) begin
			if (final_byte) begin
				inside_q  <= 1'b0;
				hash_q    <= HASH_INIT;
				tbegin_q  <= '0;
				boff_q    <= '0;
				cbegin_q  <= '0;
				partial_q <= '0;
				pend_q    <= 2'd0;
				count_q   <= '0;
				halted_q  <= 1'b0;
			end else begin
				inside_q  <= inside_n;
				hash_q    <= hash_n;
				tbegin_q  <= tbegin_n;
				boff_q    <= boff_n;
				cbegin_q  <= cbegin_n;
				partial_q <= partial_n;
				pend_q    <= pend_n;
				count_q   <= count_n;
				halted_q  <= halted_n;
			end
		end
	end

endmodule

### rtl/whitespace_tokenizer_hash_unit.sv
// ----------------------------------------------------------------------------
// whitespace_tokenizer_hash_unit
// Splits a byte stream into whitespace tokens and reports a djb2 hash per token.
// ----------------------------------------------------------------------------
// Text bytes enter on the s_ channel, one item per byte, with s_tlast on the
// last byte of a text. Tokens leave on the m_ channel: m_tuser is set when the
// item carries a token, m_tlast marks the item caused by the final byte, which
// always produces exactly one item. Bytes that close no token produce nothing.
// Registers are written on the cfg_ channel (cfg_ready is always high); the user
// must write them only while no text is in flight, which the block does not enforce.
// Each byte goes through an input register and then combinational tokenizer
// logic into the output register, from which its result is offered on m_.
// While the receiver keeps up, one byte is taken every cycle; the per-text
// state loop (hash, offsets, count) closes through the combinational logic.
// When the receiver stalls, one more byte is held in the input register and
// s_tready falls only when that byte would need the full output register.
// Reset clears the channels, restores register defaults and starts a new text.
// ----------------------------------------------------------------------------
module whitespace_tokenizer_hash_unit import wth_pkg::*; #(
	parameter int unsigned OFFSET_WIDTH = 24,
	parameter int unsigned COUNT_WIDTH  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // text_byte
	input  logic                 s_tlast,   // final_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// hash, start_offset, end_offset, tokens_so_far, zero fill
	output logic [((HASH_W+2*OFFSET_WIDTH+COUNT_WIDTH+7)/8)*8-1:0] m_tdata,
	output logic                 m_tuser,   // token_valid
	output logic                 m_tlast,   // done_res
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int unsigned PAYLOAD_W = HASH_W + 2*OFFSET_WIDTH + COUNT_WIDTH;
	localparam int unsigned TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

	cfg_t cfg_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;
	logic       fire;

	logic                    has_result;
	logic                    token_valid;
	logic [HASH_W-1:0]       res_hash;
	logic [OFFSET_WIDTH-1:0] start_offset;
	logic [OFFSET_WIDTH-1:0] end_offset;
	logic [COUNT_WIDTH-1:0]  tokens_so_far;

	logic               out_valid_q;
	logic [TDATA_W-1:0] out_data_q;
	logic               out_user_q;
	logic               out_last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lowercase_mode   <= 1'b0;
			cfg_q.drop_punctuation <= 1'b0;
			cfg_q.utf8_mode        <= 1'b0;
			cfg_q.token_limit      <= LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOWERCASE:   cfg_q.lowercase_mode   <= cfg_data[0];
				REG_DROP_PUNCT:  cfg_q.drop_punctuation <= cfg_data[0];
				REG_UTF8:        cfg_q.utf8_mode        <= cfg_data[0];
				REG_TOKEN_LIMIT: cfg_q.token_limit      <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// an item that yields nothing never waits on the output side
	assign fire     = valid_s1 && (!has_result || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			final_s1 <= s_tlast;
		end
	end

	wth_engine #(
		.OFFSET_WIDTH (OFFSET_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.text_byte     (byte_s1),
		.final_byte    (final_s1),
		.fire          (fire),
		.has_result    (has_result),
		.token_valid   (token_valid),
		.res_hash      (res_hash),
		.start_offset  (start_offset),
		.end_offset    (end_offset),
		.tokens_so_far (tokens_so_far)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			out_data_q <= TDATA_W'({tokens_so_far, end_offset, start_offset, res_hash});
			out_user_q <= token_valid;
			out_last_q <= final_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

### sim/token_stream_checker.sv
// ----------------------------------------------------------------------------
// token_stream_checker
// Watches the byte, token and register channels of the tokenizer, tracks its
// own copy of the per-text state and registers, and compares every token item
// that leaves the block with the oldest predicted one.
// ----------------------------------------------------------------------------
module token_stream_checker import wth_pkg::*; #(
	parameter int unsigned OFFSET_WIDTH = 24,
	parameter int unsigned COUNT_WIDTH  = 16,
	parameter int unsigned TDATA_W      = ((HASH_W+2*OFFSET_WIDTH+COUNT_WIDTH+7)/8)*8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [7:0]           s_tdata,   // text_byte
	input  logic                 s_tlast,   // final_byte
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// hash, start_offset, end_offset, tokens_so_far, zero fill
	input  logic [TDATA_W-1:0]   m_tdata,
	input  logic                 m_tuser,   // token_valid
	input  logic                 m_tlast,   // done_res
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output int                   fail_count,
	output int                   outstanding
);

	typedef struct packed {
		logic                    has_token;
		logic [HASH_W-1:0]       hash;
		logic [OFFSET_WIDTH-1:0] start_ofs;
		logic [OFFSET_WIDTH-1:0] end_ofs;
		logic                    text_done;
		logic [COUNT_WIDTH-1:0]  count;
	} token_rec_t;

	token_rec_t expected_tokens[$];
	int         fails;

	// shadow registers and per-text state
	cfg_t                    cfg;
	logic                    open_tok;
	logic [HASH_W-1:0]       tok_hash;
	logic [OFFSET_WIDTH-1:0] tok_start;
	logic [OFFSET_WIDTH-1:0] ofs;
	logic [OFFSET_WIDTH-1:0] char_ofs;
	logic [CP_WIDTH-1:0]     cp_accum;
	logic [1:0]              cont_left;
	logic [COUNT_WIDTH-1:0]  tok_total;
	logic                    stopped;

	function automatic void restart_text();
		open_tok    = 1'b0;
		tok_hash    = HASH_INIT;
		tok_start   = '0;
		ofs         = '0;
		char_ofs    = '0;
		cp_accum    = '0;
		cont_left   = '0;
		tok_total   = '0;
		stopped     = 1'b0;
	endfunction

	function automatic logic limit_hit();
		return (tok_total >= cfg.token_limit) || (tok_total == '1);
	endfunction

	function automatic logic splits_token(input logic [CP_WIDTH-1:0] c);
		logic blank, punct;
		blank = (c == 21'h20) || (c == 21'h09) || (c == 21'h0A) || (c == 21'h0D);
		punct = (c >= 21'h21 && c <= 21'h2F) || (c >= 21'h3A && c <= 21'h40) ||
		        (c >= 21'h5B && c <= 21'h60) || (c >= 21'h7B && c <= 21'h7E);
		return blank || (cfg.drop_punctuation && punct);
	endfunction

	// advance the text by one byte and queue the token item it causes, if any
	function automatic void tokenize_byte(input logic [7:0] b, input logic fin);
		token_rec_t          rec;
		logic                have;
		logic [CP_WIDTH-1:0] cp;
		rec  = '0;
		have = 1'b0;
		cp   = '0;
		if (!stopped && limit_hit())
			stopped = 1'b1;
		if (!stopped) begin
			if (cfg.utf8_mode) begin
				if (cont_left == 0) begin
					char_ofs = ofs;
					if (b < ASCII_TOP) begin
						cp   = CP_WIDTH'(b);
						have = 1'b1;
					end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
						cp_accum  = CP_WIDTH'(b & LEAD2_BITS);
						cont_left = 2'd1;
					end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
						cp_accum  = CP_WIDTH'(b & LEAD3_BITS);
						cont_left = 2'd2;
					end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
						cp_accum  = CP_WIDTH'(b & LEAD4_BITS);
						cont_left = 2'd3;
					end else begin
						stopped = 1'b1;
					end
				end else begin
					// continuation bytes are taken as they come, low six bits only
					cp_accum  = (cp_accum << 6) | CP_WIDTH'(b & CONT_BITS);
					cont_left = cont_left - 2'd1;
					if (cont_left == 0) begin
						cp   = cp_accum;
						have = 1'b1;
					end
				end
				if (!stopped)
					ofs = ofs + OFFSET_WIDTH'(1);
				if (fin && !stopped && cont_left != 0)
					stopped = 1'b1;
			end else begin
				cont_left = '0;
				char_ofs  = ofs;
				ofs       = ofs + OFFSET_WIDTH'(1);
				cp        = CP_WIDTH'(b);
				have      = 1'b1;
			end

			if (have) begin
				if (splits_token(cp)) begin
					if (open_tok) begin
						rec.has_token = 1'b1;
						rec.hash      = tok_hash;
						rec.start_ofs = tok_start;
						rec.end_ofs   = char_ofs;
						tok_total     = tok_total + COUNT_WIDTH'(1);
						open_tok      = 1'b0;
						tok_hash      = HASH_INIT;
						if (limit_hit())
							stopped = 1'b1;
					end
				end else begin
					if (!open_tok) begin
						tok_start = char_ofs;
						open_tok  = 1'b1;
					end
					if (cfg.lowercase_mode && cp >= 21'h41 && cp <= 21'h5A)
						cp = cp + 21'h20;
					tok_hash = tok_hash * 32'd33 + HASH_W'(cp);
				end
			end
		end

		// the final byte flushes an open token unless the limit is used up
		if (fin && !rec.has_token && open_tok && !limit_hit()) begin
			rec.has_token = 1'b1;
			rec.hash      = tok_hash;
			rec.start_ofs = tok_start;
			rec.end_ofs   = stopped ? char_ofs : ofs;
			tok_total     = tok_total + COUNT_WIDTH'(1);
		end

		if (rec.has_token || fin) begin
			rec.text_done = fin;
			rec.count     = tok_total;
			expected_tokens.push_back(rec);
		end
		if (fin)
			restart_text();
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		token_rec_t got, want;
		if (!arst_n) begin
			cfg.lowercase_mode   = 1'b0;
			cfg.drop_punctuation = 1'b0;
			cfg.utf8_mode        = 1'b0;
			cfg.token_limit      = LIMIT_RST;
			restart_text();
			expected_tokens.delete();
			fails = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.has_token = m_tuser;
				got.hash      = m_tdata[HASH_W-1:0];
				got.start_ofs = m_tdata[HASH_W +: OFFSET_WIDTH];
				got.end_ofs   = m_tdata[HASH_W+OFFSET_WIDTH +: OFFSET_WIDTH];
				got.count     = m_tdata[HASH_W+2*OFFSET_WIDTH +: COUNT_WIDTH];
				got.text_done = m_tlast;
				if (expected_tokens.size() == 0) begin
					fails++;
					$display("%0t: unexpected item valid=%0d hash=%h start=%0d end=%0d done=%0d count=%0d",
						$time, got.has_token, got.hash, got.start_ofs, got.end_ofs,
						got.text_done, got.count);
				end else begin
					want = expected_tokens.pop_front();
					if (got !== want) begin
						fails++;
						$display("%0t: mismatch expected valid=%0d hash=%h start=%0d end=%0d done=%0d count=%0d",
							$time, want.has_token, want.hash, want.start_ofs, want.end_ofs,
							want.text_done, want.count);
						$display("%0t:          actual   valid=%0d hash=%h start=%0d end=%0d done=%0d count=%0d",
							$time, got.has_token, got.hash, got.start_ofs, got.end_ofs,
							got.text_done, got.count);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LOWERCASE:   cfg.lowercase_mode   = cfg_data[0];
					REG_DROP_PUNCT:  cfg.drop_punctuation = cfg_data[0];
					REG_UTF8:        cfg.utf8_mode        = cfg_data[0];
					REG_TOKEN_LIMIT: cfg.token_limit      = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				tokenize_byte(s_tdata, s_tlast);
			fail_count  <= fails;
			outstanding <= expected_tokens.size();
		end
	end

endmodule

### sim/tb_whitespace_tokenizer_hash_unit.sv
// ----------------------------------------------------------------------------
// tb_whitespace_tokenizer_hash_unit
// Drives texts into the tokenizer under several register settings: a directed
// set of corner texts first, then random texts of mixed ASCII and UTF-8 with
// random stalls on both channels. The checker beside the block predicts and
// compares every token item.
// ----------------------------------------------------------------------------
module tb_whitespace_tokenizer_hash_unit;
	import wth_pkg::*;

	localparam int unsigned OW        = 24;
	localparam int unsigned CW        = 16;
	localparam int unsigned TDATA_W   = ((HASH_W+2*OW+CW+7)/8)*8;
	localparam int          LATENCY   = 2;
	localparam int          LONG_HOLD = 300;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = '0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;

	int   fail_count;
	int   outstanding;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic stall_req     = 1'b0;
	logic stall_seen    = 1'b0;
	int   hold_left     = 0;
	logic [7:0] text_bytes[$];

	always #5 clk = ~clk;

	whitespace_tokenizer_hash_unit #(
		.OFFSET_WIDTH(OW),
		.COUNT_WIDTH (CW)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	token_stream_checker #(
		.OFFSET_WIDTH(OW),
		.COUNT_WIDTH (CW)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	// receiver: random ready, or a long hold-off after each toggle of stall_req
	always @(posedge clk) begin
		if (stall_seen != stall_req) begin
			stall_seen <= stall_req;
			hold_left  <= LONG_HOLD;
			m_tready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// leaves tvalid high on return; the caller sends again or lowers it in the same step
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_text();
		for (int i = 0; i < text_bytes.size(); i++)
			send_byte(text_bytes[i], i == text_bytes.size() - 1);
	endtask

	task automatic wait_drained();
		repeat (LATENCY) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// one-bit registers get random upper data bits, only bit 0 counts
	task automatic set_modes(input logic lc, input logic dp, input logic u8,
	                         input logic [LIMIT_W-1:0] lim);
		write_reg(REG_LOWERCASE,   {15'($urandom_range(32767)), lc});
		write_reg(REG_DROP_PUNCT,  {15'($urandom_range(32767)), dp});
		write_reg(REG_UTF8,        {15'($urandom_range(32767)), u8});
		write_reg(REG_TOKEN_LIMIT, lim);
	endtask

	function automatic void make_text();
		int          nchars, r, k;
		logic [7:0]  b;
		text_bytes.delete();
		nchars = $urandom_range(1, 10);
		for (int i = 0; i < nchars; i++) begin
			r = $urandom_range(99);
			if (r < 40) begin
				b = 8'h41 + 8'($urandom_range(25));
				if ($urandom_range(1))
					b = b | 8'h20;
				text_bytes.push_back(b);
			end else if (r < 58) begin
				case ($urandom_range(3))
					0: text_bytes.push_back(8'h20);
					1: text_bytes.push_back(8'h09);
					2: text_bytes.push_back(8'h0A);
					default: text_bytes.push_back(8'h0D);
				endcase
			end else if (r < 68) begin
				k = $urandom_range(31);
				if (k < 15)      b = 8'h21 + 8'(k);
				else if (k < 22) b = 8'h3A + 8'(k - 15);
				else if (k < 28) b = 8'h5B + 8'(k - 22);
				else             b = 8'h7B + 8'(k - 28);
				text_bytes.push_back(b);
			end else if (r < 75) begin
				text_bytes.push_back(8'h30 + 8'($urandom_range(9)));
			end else if (r < 92) begin
				k = $urandom_range(1, 3);
				case (k)
					1: text_bytes.push_back(LEAD2_PAT | 8'($urandom_range(31)));
					2: text_bytes.push_back(LEAD3_PAT | 8'($urandom_range(15)));
					default: text_bytes.push_back(LEAD4_PAT | 8'($urandom_range(7)));
				endcase
				// continuation bytes are not checked, so now and then send any byte
				for (int j = 0; j < k; j++) begin
					if ($urandom_range(9) == 0)
						text_bytes.push_back(8'($urandom_range(255)));
					else
						text_bytes.push_back(ASCII_TOP | 8'($urandom_range(63)));
				end
			end else if (r < 97) begin
				text_bytes.push_back(8'($urandom_range(255)));
			end else begin
				if ($urandom_range(1))
					text_bytes.push_back(8'h80 + 8'($urandom_range(63)));
				else
					text_bytes.push_back(8'hF8 + 8'($urandom_range(7)));
			end
		end
		// a lone lead byte at the end leaves the last sequence cut short
		if ($urandom_range(19) == 0)
			text_bytes.push_back(LEAD2_PAT | 8'($urandom_range(31)));
	endfunction

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [LIMIT_W-1:0] lim;
		int                 sent;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed texts
		set_modes(1'b1, 1'b1, 1'b1, LIMIT_RST);
		// upper case folded, comma splits, overlong space, euro sign, bad lead halts
		text_bytes = '{8'h41, 8'h7A, 8'h2C, 8'hC0, 8'hA0, 8'hE2, 8'h82, 8'hAC, 8'hFF,
		               8'h71, 8'h0A};
		send_text();
		// four-byte sequence cut short by the final byte
		text_bytes = '{8'h78, 8'hF0, 8'h9F};
		send_text();
		s_tvalid <= 1'b0;
		wait_drained();
		write_reg(REG_TOKEN_LIMIT, '0);
		text_bytes = '{8'h61, 8'h62, 8'h20, 8'h63};
		send_text();
		s_tvalid <= 1'b0;
		wait_drained();
		set_modes(1'b0, 1'b0, 1'b0, 16'd1);
		// byte mode, limit of one: rest of text ignored after first token
		text_bytes = '{8'h80, 8'h20, 8'h7A, 8'hFF};
		send_text();
		s_tvalid <= 1'b0;
		wait_drained();
		// utf-8 switched off while a sequence is pending
		set_modes(1'b0, 1'b0, 1'b1, LIMIT_RST);
		send_byte(8'h6B, 1'b0);
		send_byte(8'hC3, 1'b0);
		s_tvalid <= 1'b0;
		wait_drained();
		write_reg(REG_UTF8, '0);
		send_byte(8'hA9, 1'b0);
		send_byte(8'h20, 1'b1);
		s_tvalid <= 1'b0;
		wait_drained();

		// random texts over three idle profiles
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct <= 83;
				end
				1: begin
					send_idle_pct = 83;
					recv_idle_pct <= 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
				end
			endcase
			for (int ph = 0; ph < 5; ph++) begin
				case ($urandom_range(5))
					0: lim = '0;
					1: lim = 16'd1;
					2: lim = 16'd2;
					3: lim = 16'd3;
					4: lim = LIMIT_RST;
					default: lim = LIMIT_W'($urandom_range(65535));
				endcase
				set_modes(1'($urandom_range(1)), 1'($urandom_range(1)),
				          $urandom_range(3) != 0, lim);
				if (mode == 2 && ph == 1)
					stall_req <= ~stall_req;
				sent = 0;
				while (sent < 24) begin
					make_text();
					send_text();
					sent += text_bytes.size();
				end
				s_tvalid <= 1'b0;
				wait_drained();
			end
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
